@@ rtl/crcgs_pkg.sv @@
// Shared types and constants for the bit-serial CRC generator and checker.
package crcgs_pkg;

  localparam int MAX_DEGREE = 16;
  localparam int REM_W = MAX_DEGREE;
  localparam int DEG_W = $clog2(MAX_DEGREE + 1);
  localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  localparam int GEN_LOW_W = 16;
  localparam int GEN_DEG_W = 5;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [GEN_LOW_W-1:0] GEN_LOW_RESET = 16'h8005;
  localparam logic [GEN_DEG_W-1:0] GEN_DEG_RESET = 5'd16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GEN_LOW    = 2'd0,
    CFG_GEN_DEGREE = 2'd1,
    CFG_CHECK_MODE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_ECHO        = 2'd0,
    KIND_ECHO_APPEND = 2'd1,
    KIND_CHECK       = 2'd2
  } item_kind_t;

  typedef struct packed {
    logic data_bit;
    logic frame_end;
  } in_item_t;

  typedef struct packed {
    logic code_bit;
    logic is_remainder;
    logic run_last;
    logic error_found;
  } out_item_t;

  typedef struct packed {
    item_kind_t        kind;
    logic              data_bit;
    logic [REM_W-1:0]  rem;
    logic [DEG_W-1:0]  degree;
    logic              error;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/crc_generate_check_serial_unit.sv @@
// Top level of the bit-serial CRC generator and checker.
// The block takes one data bit per clock cycle and updates its running remainder in that same
// cycle; result items also leave at one per cycle unless result_stall is high. In generate
// mode each bit yields one echoed result, and the frame's last bit adds one result per bit of
// the effective generator degree after its echoed bit. In check mode only the frame's last bit
// yields a result. A four-item queue between the remainder logic and the output sequencer absorbs
// appended remainder, so input stalls only when the queue fills while the output drains or waits.
// Configuration writes are always ready and take effect on the next bit.
module crc_generate_check_serial_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crcgs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crcgs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              data_valid,
  output logic                              data_stall,
  input  crcgs_pkg::in_item_t               data,
  output logic                              result_valid,
  input  logic                              result_stall,
  output crcgs_pkg::out_item_t              result
);
  import crcgs_pkg::*;

  q_status_t q_status;
  q_entry_t  q_push_entry;
  q_entry_t  q_head;
  logic      q_push;
  logic      q_pop;

  crcgs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data         (data),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_push_entry (q_push_entry)
  );

  crcgs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  crcgs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .q_status     (q_status),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ rtl/crcgs_front.sv @@
// Front end: configuration registers, remainder update per bit, and item classification.
module crcgs_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crcgs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [crcgs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              data_valid,
  output logic                              data_stall,
  input  crcgs_pkg::in_item_t               data,
  input  crcgs_pkg::q_status_t              q_status,
  output logic                              q_push,
  output crcgs_pkg::q_entry_t               q_push_entry
);
  import crcgs_pkg::*;

  logic [GEN_LOW_W-1:0] gen_low;
  logic [GEN_DEG_W-1:0] gen_degree;
  logic                 check_mode;
  logic [REM_W-1:0]     remainder;
  logic [REM_W-1:0]     remainder_next;

  logic [DEG_W-1:0] eff_deg;
  logic [DEG_W-1:0] deg_m1;
  logic [REM_W-1:0] mask;
  logic [REM_W-1:0] poly;
  logic [REM_W-1:0] rem_m;
  logic [REM_W-1:0] rem_div;
  logic             top;
  logic             accept;

  assign cfg_ready = 1'b1;
  assign data_stall = q_status.full;
  assign accept = data_valid && !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_low <= GEN_LOW_RESET;
      gen_degree <= GEN_DEG_RESET;
      check_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GEN_LOW:    gen_low <= cfg_data[GEN_LOW_W-1:0];
        CFG_GEN_DEGREE: gen_degree <= cfg_data[GEN_DEG_W-1:0];
        CFG_CHECK_MODE: check_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (gen_degree == '0) begin
      eff_deg = DEG_W'(1);
    end else if (int'(gen_degree) > MAX_DEGREE) begin
      eff_deg = DEG_W'(MAX_DEGREE);
    end else begin
      eff_deg = DEG_W'(gen_degree);
    end
    deg_m1 = eff_deg - DEG_W'(1);
    for (int i = 0; i < REM_W; i++) begin
      mask[i] = (i < int'(eff_deg));
    end
    poly = REM_W'(gen_low) & mask;
    rem_m = remainder & mask;
    top = rem_m[deg_m1[IDX_W-1:0]];
  end

  always_comb begin
    q_push_entry.data_bit = data.data_bit;
    q_push_entry.degree = eff_deg;
    if (check_mode) begin
      rem_div = ((rem_m << 1) | REM_W'(data.data_bit)) & mask;
      if (top) begin
        rem_div = rem_div ^ poly;
      end
      q_push_entry.kind = KIND_CHECK;
      q_push_entry.error = (rem_div != '0);
    end else begin
      rem_div = (rem_m << 1) & mask;
      if (top ^ data.data_bit) begin
        rem_div = rem_div ^ poly;
      end
      q_push_entry.kind = data.frame_end ? KIND_ECHO_APPEND : KIND_ECHO;
      q_push_entry.error = 1'b0;
    end
    q_push_entry.rem = rem_div;
    remainder_next = data.frame_end ? '0 : rem_div;
    q_push = accept && (!check_mode || data.frame_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (accept) begin
      remainder <= remainder_next;
    end
  end

endmodule

@@ rtl/crcgs_queue.sv @@
// Short queue of classified items between the front end and the output sequencer.
module crcgs_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  crcgs_pkg::q_entry_t  push_entry,
  input  logic                 pop,
  output crcgs_pkg::q_entry_t  head,
  output crcgs_pkg::q_status_t status
);
  import crcgs_pkg::*;

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop = pop && !status.empty;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/crcgs_back.sv @@
// Back end: turns queued items into result items and shifts out the appended remainder.
module crcgs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  crcgs_pkg::q_entry_t  head,
  input  crcgs_pkg::q_status_t q_status,
  output logic                 q_pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output crcgs_pkg::out_item_t result
);
  import crcgs_pkg::*;

  logic [REM_W-1:0] ser_rem;
  logic [REM_W-1:0] ser_rem_next;
  logic [DEG_W-1:0] count;
  logic [DEG_W-1:0] count_next;
  logic [DEG_W-1:0] count_m1;
  logic             result_valid_next;
  out_item_t        result_next;
  logic             load;

  assign load = !result_valid || !result_stall;
  assign count_m1 = count - DEG_W'(1);

  always_comb begin
    ser_rem_next = ser_rem;
    count_next = count;
    result_valid_next = result_valid;
    result_next = result;
    q_pop = 1'b0;
    if (load) begin
      if (count != '0) begin
        result_valid_next = 1'b1;
        result_next.code_bit = ser_rem[count_m1[IDX_W-1:0]];
        result_next.is_remainder = 1'b1;
        result_next.run_last = (count == DEG_W'(1));
        result_next.error_found = 1'b0;
        count_next = count_m1;
      end else if (!q_status.empty) begin
        q_pop = 1'b1;
        result_valid_next = 1'b1;
        case (head.kind)
          KIND_CHECK: begin
            result_next.code_bit = 1'b0;
            result_next.is_remainder = 1'b0;
            result_next.run_last = 1'b1;
            result_next.error_found = head.error;
          end
          KIND_ECHO_APPEND: begin
            result_next.code_bit = head.data_bit;
            result_next.is_remainder = 1'b0;
            result_next.run_last = 1'b0;
            result_next.error_found = 1'b0;
            ser_rem_next = head.rem;
            count_next = head.degree;
          end
          default: begin
            result_next.code_bit = head.data_bit;
            result_next.is_remainder = 1'b0;
            result_next.run_last = 1'b0;
            result_next.error_found = 1'b0;
          end
        endcase
      end else begin
        result_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      count <= '0;
    end else begin
      result_valid <= result_valid_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    ser_rem <= ser_rem_next;
  end

endmodule

@@ rtl/crcgs_checker.sv @@
// Port-level checks for the CRC generator and checker, bound to the top level.
module crcgs_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 data_valid,
  input logic                 data_stall,
  input crcgs_pkg::in_item_t  data,
  input logic                 result_valid,
  input logic                 result_stall,
  input crcgs_pkg::out_item_t result
);

  assert property (@(posedge clk) disable iff (rst)
    data_valid && data_stall |=> data_valid && $stable(data))
    else $error("Stalled input item changed or was withdrawn.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("Stalled result item changed or was dropped.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error_found |-> result.run_last && !result.is_remainder)
    else $error("Error flag set on an item that does not end a check frame.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && result.is_remainder && !result.run_last
      |=> result_valid && result.is_remainder)
    else $error("Appended remainder ended without its last bit.");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_remainder |-> !result.error_found)
    else $error("Remainder bit carries an error flag.");

endmodule

bind crc_generate_check_serial_unit crcgs_checker u_crcgs_checker (.*);
